// ===== rtl/sdel_pkg.sv =====
`default_nettype none

package sdel_pkg;

   localparam int FLAG_W  = 5;
   localparam int STEPS_W = 8;
   localparam int TIME_W  = 32;
   localparam int DEB_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // flag bit positions
   localparam int FLAG_SET        = 0;
   localparam int FLAG_RESET      = 1;
   localparam int FLAG_HOLD       = 2;
   localparam int FLAG_DELAY      = 3;
   localparam int FLAG_DELAY_DONE = 4;

   localparam logic [STEPS_W-1:0] STEP_LIMIT = 8'd250;
   localparam logic [STEPS_W-1:0] STEP_MAX   = 8'd251;
   localparam logic [STEPS_W-1:0] STEP_SET   = 8'd2;
   localparam logic [STEPS_W-1:0] STEP_ONE   = 8'd1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_DELAY = 2'd2;

   localparam logic [DEB_W-1:0]   DEBOUNCE_RST  = 16'd50;
   localparam logic [STEPS_W-1:0] HOLD_RST      = 8'd20;
   localparam logic [TIME_W-1:0]  OFF_DELAY_RST = 32'd10000;

   // action codes
   localparam logic ACT_UPDATE = 1'b0;
   localparam logic ACT_TAKE   = 1'b1;

   typedef struct packed {
      logic              action;
      logic              switch_level;
      logic [TIME_W-1:0] now_ms;
      logic [FLAG_W-1:0] take_mask;
   } req_item_type;

   typedef struct packed {
      logic [FLAG_W-1:0]  taken_flags;
      logic [STEPS_W-1:0] current_steps;
      logic [FLAG_W-1:0]  pending_flags;
   } rsp_item_type;

   typedef struct packed {
      logic [DEB_W-1:0]   debounce_ms;
      logic [STEPS_W-1:0] hold_count;
      logic [TIME_W-1:0]  off_delay_ms;
   } cfg_type;

   typedef struct packed {
      logic [STEPS_W-1:0] press_steps;
      logic [TIME_W-1:0]  last_change_ms;
      logic [FLAG_W-1:0]  event_flags;
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/sdel_csr.sv =====
`default_nettype none

module sdel_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [sdel_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sdel_pkg::CSR_DATA_W-1:0] csr_data,
   output sdel_pkg::cfg_type                   cfg
);
   import sdel_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEBOUNCE:  cfg_in.debounce_ms  = csr_data[DEB_W-1:0];
            CSR_HOLD:      cfg_in.hold_count   = csr_data[STEPS_W-1:0];
            CSR_OFF_DELAY: cfg_in.off_delay_ms = csr_data[TIME_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms  <= DEBOUNCE_RST;
         cfg_ff.hold_count   <= HOLD_RST;
         cfg_ff.off_delay_ms <= OFF_DELAY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sdel_update.sv =====
`default_nettype none

module sdel_update (
   input  wire sdel_pkg::req_item_type item,
   input  wire sdel_pkg::state_type    state,
   input  wire sdel_pkg::cfg_type      cfg,
   output sdel_pkg::state_type         state_next,
   output sdel_pkg::rsp_item_type      result
);
   import sdel_pkg::*;

   logic [TIME_W-1:0]  elapsed;
   logic               step_go;
   logic               release_go;
   logic [STEPS_W-1:0] steps_inc;
   logic [FLAG_W-1:0]  flags;
   logic [FLAG_W-1:0]  taken;

   assign elapsed   = item.now_ms - state.last_change_ms;
   assign steps_inc = state.press_steps + STEP_ONE;
   assign step_go   = item.switch_level &&
                      ((state.press_steps == '0) ||
                       ((state.press_steps <= STEP_LIMIT) &&
                        (elapsed > TIME_W'(cfg.debounce_ms))));
   assign release_go = !item.switch_level && (state.press_steps != '0);

   always_comb begin
      state_next = state;
      flags      = state.event_flags;
      taken      = '0;
      if (item.action == ACT_TAKE) begin
         taken = state.event_flags & item.take_mask;
         flags = state.event_flags & ~item.take_mask;
      end else begin
         if (step_go) begin
            state_next.press_steps    = steps_inc;
            state_next.last_change_ms = item.now_ms;
            if (steps_inc == STEP_SET) flags[FLAG_SET] = 1'b1;
         end else if (release_go) begin
            state_next.press_steps    = '0;
            state_next.last_change_ms = item.now_ms;
            flags[FLAG_RESET] = 1'b1;
            if (state.press_steps > STEP_ONE) flags[FLAG_DELAY_DONE] = 1'b0;
            if (state.press_steps > cfg.hold_count) flags[FLAG_HOLD] = 1'b1;
         end
         // a change this item leaves zero idle time, so no delay check can fire
         if (!step_go && !release_go && (elapsed > cfg.off_delay_ms) &&
             !flags[FLAG_DELAY_DONE]) begin
            flags[FLAG_DELAY]      = 1'b1;
            flags[FLAG_DELAY_DONE] = 1'b1;
         end
      end
      state_next.event_flags = flags;
      result.taken_flags     = taken;
      result.current_steps   = state_next.press_steps;
      result.pending_flags   = flags;
   end

endmodule

`default_nettype wire

// ===== rtl/switch_debounce_event_latch_core.sv =====
`default_nettype none

// Switch debounce and event latch.
// Input channel (req_valid / req_stall / req_item): one item per accept, either
// an update carrying the raw switch level and the millisecond time, or a take
// carrying a mask of event flags to read and clear.
// Result channel (rsp_valid / rsp_stall / rsp_item): exactly one result per
// item, in order: flags taken, press step count and all pending flags.
// Configuration (csr_valid / csr_ready / csr_index / csr_data): always ready;
// index 0 debounce period, 1 hold count, 2 off delay. Write only when idle.
// An accepted item goes through the input register, then the result register.
// Throughput: one item per cycle unless rsp_stall holds a waiting result; the
// input register, combinational update and result register pass one per clock.
// Stall: a stalled result holds in the result register while the input
// register still takes one more item; req_stall rises once both are full.
// Reset: synchronous, clears steps, last change time and flags to zero and
// loads the register defaults (50, 20, 10000). No clearing pass is needed.
module switch_debounce_event_latch_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire sdel_pkg::req_item_type          req_item,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output sdel_pkg::rsp_item_type              rsp_item,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [sdel_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sdel_pkg::CSR_DATA_W-1:0] csr_data
);
   import sdel_pkg::*;

   cfg_type      cfg;
   logic         in_valid_ff;
   logic         in_valid_in;
   req_item_type in_item_ff;
   state_type    state_ff;
   state_type    state_next;
   rsp_item_type result;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_item_type rsp_item_ff;
   logic         advance;
   logic         req_take;

   sdel_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sdel_update u_update (
      .item       (in_item_ff),
      .state      (state_ff),
      .cfg        (cfg),
      .state_next (state_next),
      .result     (result)
   );

   // move the held item into the result register when that slot frees up
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) state_ff <= state_next;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_item_ff  <= req_item;
      if (advance)  rsp_item_ff <= result;
   end

`ifndef NO_ASSERTIONS
   a_steps_ceiling: assert property (@(posedge clock) disable iff (reset)
      state_ff.press_steps <= STEP_MAX)
      else $error("press step count above ceiling");

   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("held input item lost or changed");

   a_taken_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_item_ff.taken_flags & rsp_item_ff.pending_flags) == '0))
      else $error("taken flag still pending");

   a_state_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without an item");
`endif

endmodule

`default_nettype wire

// ===== sim/switch_debounce_event_latch_core_test.sv =====
`timescale 1ns / 100ps

module switch_debounce_event_latch_core_test;
   import sdel_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam logic [STEPS_W-1:0]   STEP_CAP  = 8'd250;
   localparam int BLOCK_ITEMS = 100;
   localparam int HOLD_OFF_CYCLES = 80;

   typedef struct {
      req_item_type item;
      bit           pinned;
      rsp_item_type report;
   } probe_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_item_type          req_item  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_item_type          rsp_item;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   // travels with req_item: a typed-in report replaces the predicted one
   bit           pin_valid  = 1'b0;
   rsp_item_type pin_report = '0;

   // predictor copy of registers and state
   logic [DEB_W-1:0]   deb_period;
   logic [STEPS_W-1:0] hold_limit;
   logic [TIME_W-1:0]  idle_limit;
   logic [STEPS_W-1:0] steps_m;
   logic [TIME_W-1:0]  last_edge_ms;
   logic [FLAG_W-1:0]  flags_m;

   rsp_item_type  awaited_reports[$];
   probe_row_type probe_rows[$];

   int mismatch_count = 0;
   int items_sent     = 0;
   int gap_pct        = 36;
   int stall_pct      = 59;
   int holds_asked    = 0;
   int holds_granted  = 0;
   int hold_left      = 0;

   // stimulus-side view of the current settings and time
   logic [DEB_W-1:0]  deb_sel = 16'd50;
   logic [TIME_W-1:0] off_sel = 32'd10000;
   logic [TIME_W-1:0] sim_now = '0;

   switch_debounce_event_latch_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   task automatic debounce_and_latch(input req_item_type it, output rsp_item_type rp);
      logic [TIME_W-1:0] since;
      logic [FLAG_W-1:0] grabbed;
      grabbed = '0;
      if (it.action == ACT_TAKE) begin
         grabbed = flags_m & it.take_mask;
         flags_m = flags_m & ~it.take_mask;
      end else begin
         if (it.switch_level) begin
            since = it.now_ms - last_edge_ms;
            if (steps_m == 0 || (steps_m <= STEP_CAP && since > {16'd0, deb_period})) begin
               steps_m = steps_m + 1'b1;
               last_edge_ms = it.now_ms;
               if (steps_m == 8'd2)
                  flags_m[FLAG_SET] = 1'b1;
            end
         end else if (steps_m != 0) begin
            last_edge_ms = it.now_ms;
            flags_m[FLAG_RESET] = 1'b1;
            // a single-step press leaves the delay-done mark alone
            if (steps_m > 8'd1)
               flags_m[FLAG_DELAY_DONE] = 1'b0;
            if (steps_m > hold_limit)
               flags_m[FLAG_HOLD] = 1'b1;
            steps_m = '0;
         end
         since = it.now_ms - last_edge_ms;
         if (since > idle_limit && !flags_m[FLAG_DELAY_DONE]) begin
            flags_m[FLAG_DELAY]      = 1'b1;
            flags_m[FLAG_DELAY_DONE] = 1'b1;
         end
      end
      rp.taken_flags   = grabbed;
      rp.current_steps = steps_m;
      rp.pending_flags = flags_m;
   endtask

   always @(posedge clock) begin : monitor
      rsp_item_type predicted;
      rsp_item_type want;
      if (reset) begin
         deb_period   = 16'd50;
         hold_limit   = 8'd20;
         idle_limit   = 32'd10000;
         steps_m      = '0;
         last_edge_ms = '0;
         flags_m      = '0;
         awaited_reports.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEBOUNCE:  deb_period = csr_data[DEB_W-1:0];
               CSR_HOLD:      hold_limit = csr_data[STEPS_W-1:0];
               CSR_OFF_DELAY: idle_limit = csr_data[TIME_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            debounce_and_latch(req_item, predicted);
            awaited_reports.push_back(pin_valid ? pin_report : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_reports.size() == 0) begin
               $error("unexpected result: taken %0h steps %0d pending %0h",
                      rsp_item.taken_flags, rsp_item.current_steps,
                      rsp_item.pending_flags);
               mismatch_count++;
            end else begin
               want = awaited_reports.pop_front();
               if (rsp_item.taken_flags !== want.taken_flags) begin
                  $error("taken_flags: expected %0h, got %0h",
                         want.taken_flags, rsp_item.taken_flags);
                  mismatch_count++;
               end
               if (rsp_item.current_steps !== want.current_steps) begin
                  $error("current_steps: expected %0d, got %0d",
                         want.current_steps, rsp_item.current_steps);
                  mismatch_count++;
               end
               if (rsp_item.pending_flags !== want.pending_flags) begin
                  $error("pending_flags: expected %0h, got %0h",
                         want.pending_flags, rsp_item.pending_flags);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // result side: random stall, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_granted != holds_asked) begin
         holds_granted <= holds_granted + 1;
         hold_left     <= HOLD_OFF_CYCLES;
         rsp_stall     <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   function automatic probe_row_type row(input logic act, input logic lvl,
                                         input logic [TIME_W-1:0] now,
                                         input logic [FLAG_W-1:0] mask, input bit pinned,
                                         input logic [FLAG_W-1:0] taken,
                                         input logic [STEPS_W-1:0] steps,
                                         input logic [FLAG_W-1:0] pending);
      probe_row_type r;
      r.item.action        = act;
      r.item.switch_level  = lvl;
      r.item.now_ms        = now;
      r.item.take_mask     = mask;
      r.pinned             = pinned;
      r.report.taken_flags   = taken;
      r.report.current_steps = steps;
      r.report.pending_flags = pending;
      return r;
   endfunction

   task automatic offer(input req_item_type it, input bit pinned, input rsp_item_type pin);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_item   <= it;
      pin_valid  <= pinned;
      pin_report <= pin;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_update(input logic lvl, input logic [TIME_W-1:0] dt);
      req_item_type it;
      sim_now         = sim_now + dt;
      it.action       = ACT_UPDATE;
      it.switch_level = lvl;
      it.now_ms       = sim_now;
      it.take_mask    = 5'($urandom_range(0, 31));
      offer(it, 1'b0, '0);
   endtask

   task automatic send_take();
      req_item_type it;
      it.action       = ACT_TAKE;
      it.switch_level = 1'($urandom_range(0, 1));
      it.now_ms       = $urandom;
      it.take_mask    = 5'($urandom_range(0, 31));
      offer(it, 1'b0, '0);
   endtask

   function automatic logic [TIME_W-1:0] press_gap(input bit climb);
      logic [TIME_W-1:0] deb;
      deb = {16'd0, deb_sel};
      if (climb)
         return deb + 1;
      case ($urandom_range(0, 3))
         0:       return deb;
         1:       return deb + 1;
         2:       return $urandom_range(0, deb);
         default: return deb + $urandom_range(2, 100);
      endcase
   endfunction

   function automatic logic [TIME_W-1:0] idle_gap();
      case ($urandom_range(0, 3))
         0:       return off_sel;
         1:       return off_sel + 1;
         2:       return $urandom_range(0, 200);
         default: return $urandom;
      endcase
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // wait until every report is back, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      while (awaited_reports.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // a climbing press runs the step counter up to its ceiling and holds it there
   task automatic press_sequence(input bit climb);
      int len;
      int n;
      len = climb ? $urandom_range(252, 270) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++)
         send_update(1'b1, press_gap(climb));
      // now and then leave the press without a release
      if ($urandom_range(0, 3) != 0)
         send_update(1'b0, $urandom_range(0, 20));
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++)
         send_update(1'b0, idle_gap());
   endtask

   initial begin
      int k;
      int block_end;
      logic [STEPS_W-1:0] hold_sel;
      req_item_type junk;
      logic [63:0] junk_bits;

      // reset defaults: debounce 50, hold 20, off delay 10000
      probe_rows.push_back(row(ACT_TAKE,   0, 32'd0,     5'h1F, 1, 5'h00, 8'd0, 5'h00));
      probe_rows.push_back(row(ACT_UPDATE, 0, 32'd0,     5'h00, 1, 5'h00, 8'd0, 5'h00));
      probe_rows.push_back(row(ACT_UPDATE, 0, 32'd10000, 5'h1F, 1, 5'h00, 8'd0, 5'h00));
      probe_rows.push_back(row(ACT_UPDATE, 0, 32'd10001, 5'h00, 1, 5'h00, 8'd0, 5'h18));
      probe_rows.push_back(row(ACT_UPDATE, 1, 32'd10002, 5'h00, 1, 5'h00, 8'd1, 5'h18));
      probe_rows.push_back(row(ACT_UPDATE, 1, 32'd10052, 5'h00, 1, 5'h00, 8'd1, 5'h18));
      probe_rows.push_back(row(ACT_UPDATE, 1, 32'd10053, 5'h00, 1, 5'h00, 8'd2, 5'h19));
      probe_rows.push_back(row(ACT_UPDATE, 0, 32'd10060, 5'h00, 1, 5'h00, 8'd0, 5'h0B));
      probe_rows.push_back(row(ACT_TAKE,   0, 32'd0,     5'h00, 1, 5'h00, 8'd0, 5'h0B));
      probe_rows.push_back(row(ACT_TAKE,   0, 32'd0,     5'h01, 1, 5'h01, 8'd0, 5'h0A));
      probe_rows.push_back(row(ACT_TAKE,   0, 32'd0,     5'h1F, 1, 5'h0A, 8'd0, 5'h00));
      // single-step press keeps delay-done as it is
      probe_rows.push_back(row(ACT_UPDATE, 1, 32'd20000, 5'h00, 1, 5'h00, 8'd1, 5'h00));
      probe_rows.push_back(row(ACT_UPDATE, 0, 32'd20001, 5'h00, 1, 5'h00, 8'd0, 5'h02));
      // time runs backward by one: the difference wraps to the maximum
      probe_rows.push_back(row(ACT_UPDATE, 0, 32'd20000, 5'h00, 1, 5'h00, 8'd0, 5'h1A));
      probe_rows.push_back(row(ACT_UPDATE, 0, 32'hFFFF_FFFF, 5'h1F, 0, '0, '0, '0));
      probe_rows.push_back(row(ACT_UPDATE, 1, 32'hFFFF_FFF0, 5'h00, 1, 5'h00, 8'd1, 5'h1A));
      probe_rows.push_back(row(ACT_UPDATE, 1, 32'h0000_0023, 5'h00, 1, 5'h00, 8'd2, 5'h1B));
      probe_rows.push_back(row(ACT_UPDATE, 0, 32'h0000_0030, 5'h00, 1, 5'h00, 8'd0, 5'h0B));
      probe_rows.push_back(row(ACT_TAKE,   1, 32'hFFFF_FFFF, 5'h1F, 1, 5'h0B, 8'd0, 5'h00));
      probe_rows.push_back(row(ACT_UPDATE, 1, 32'h0000_0030, 5'h00, 0, '0, '0, '0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_rows[i])
         offer(probe_rows[i].item, probe_rows[i].pinned, probe_rows[i].report);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin gap_pct = 36; stall_pct = 59; end
            1:       begin gap_pct = 59; stall_pct = 36; end
            default: begin gap_pct = 0;  stall_pct = 0;  end
         endcase
         for (int b = 0; b < 4; b++) begin
            k = phase * 4 + b;
            case (k % 4)
               0:       deb_sel = 16'd0;
               1:       deb_sel = 16'hFFFF;
               2:       deb_sel = 16'($urandom_range(1, 60));
               default: deb_sel = 16'd50;
            endcase
            case (k % 3)
               0:       hold_sel = 8'd0;
               1:       hold_sel = 8'd251;
               default: hold_sel = 8'($urandom_range(1, 12));
            endcase
            case (k % 5)
               0:       off_sel = 32'd0;
               1:       off_sel = 32'hFFFF_FFFF;
               default: off_sel = $urandom_range(0, 3000);
            endcase

            drain();
            // upper data bits beyond each register's width are don't-care
            write_reg(CSR_DEBOUNCE, {16'($urandom), deb_sel});
            write_reg(CSR_HOLD, {24'($urandom), hold_sel});
            write_reg(CSR_OFF_DELAY, off_sel);
            if (k == 0)
               write_reg(CSR_SPARE, $urandom);
            csr_valid <= 1'b0;

            if (b == 0 && phase != 1)
               holds_asked++;

            block_end = items_sent + BLOCK_ITEMS;
            if (b == phase)
               press_sequence(1'b1);
            while (items_sent < block_end) begin
               case ($urandom_range(0, 99)) inside
                  [0:9]: begin
                     junk_bits = {$urandom, $urandom};
                     junk = junk_bits[$bits(req_item_type)-1:0];
                     offer(junk, 1'b0, '0);
                  end
                  [10:24]: send_take();
                  default: press_sequence(1'b0);
               endcase
            end
         end
      end

      drain();
      repeat (6) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #1000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/sdel_pkg.sv
rtl/sdel_csr.sv
rtl/sdel_update.sv
rtl/switch_debounce_event_latch_core.sv
sim/switch_debounce_event_latch_core_test.sv
